>>> hdl/assert_macros.svh
// assertion macros used by the segment unit top level
// no dependencies; expects clk_i and rst_ni in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> hdl/mscs_pkg.sv
// constants and types for the marching squares segment unit
// no dependencies
package mscs_pkg;

  localparam int GRID_SIZE  = 1024;
  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = 10;
  localparam int VAL_W      = 32;
  localparam int SCALE_W    = 24;
  localparam int OUT_W      = 34;
  localparam int COORD_W    = POS_W + FRAC_BITS + 1;
  localparam int PROD_W     = COORD_W + SCALE_W;
  localparam int DIV_STAGES = FRAC_BITS;
  localparam int CFG_IDX_W  = 2;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 2'd2;

  // edge order
  localparam int EDGE_TOP    = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_BOTTOM = 2;
  localparam int EDGE_LEFT   = 3;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_ONE,
    MODE_DIV
  } edge_mode_e;

  // cell data that travels beside the dividers
  typedef struct packed {
    logic [3:0]       cas;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    edge_mode_e [3:0] mode;
  } side_t;

endpackage

>>> hdl/mscs_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on mscs_pkg; numerator must be below denominator
module mscs_div (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [mscs_pkg::VAL_W-1:0]        num_i,
  input  logic [mscs_pkg::VAL_W-1:0]        den_i,
  output logic [mscs_pkg::FRAC_BITS-1:0]    quot_o
);
  import mscs_pkg::*;

  logic [VAL_W-1:0]     rem_q  [DIV_STAGES];
  logic [VAL_W-1:0]     den_q  [DIV_STAGES];
  logic [FRAC_BITS-1:0] quot_q [DIV_STAGES];
  logic [VAL_W-1:0]     rem_d  [DIV_STAGES];
  logic [VAL_W-1:0]     den_d  [DIV_STAGES];
  logic [FRAC_BITS-1:0] quot_d [DIV_STAGES];

  // one shift, compare and subtract per stage
  always_comb begin
    logic [VAL_W-1:0]     rp;
    logic [VAL_W-1:0]     dp;
    logic [FRAC_BITS-1:0] qp;
    logic [VAL_W:0]       r2;
    logic [VAL_W+1:0]     diff;
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        rp = num_i;
        dp = den_i;
        qp = '0;
      end else begin
        rp = rem_q[k-1];
        dp = den_q[k-1];
        qp = quot_q[k-1];
      end
      r2   = {rp, 1'b0};
      diff = {1'b0, r2} - {2'b00, dp};
      den_d[k]  = dp;
      quot_d[k] = {qp[FRAC_BITS-2:0], ~diff[VAL_W+1]};
      rem_d[k]  = diff[VAL_W+1] ? r2[VAL_W-1:0] : diff[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q[DIV_STAGES-1];

endmodule

>>> hdl/marching_squares_cell_segments_unit.sv
// top level of the marching squares segment unit
// depends on mscs_pkg, mscs_div and assert_macros.svh
//
// Use: one grid cell enters per transfer on the input channel (four Q16.16
// corners, known mask, column and row). A cell with an unknown corner, in the
// last grid column or row, or wholly on one side of the level gives nothing.
// Otherwise one segment (two for the saddle patterns, where diagonal corners
// agree) leaves on the output channel, scaled to unsigned Q18.16;
// last_segment marks the final one of a cell.
// Configuration: cfg_index_i selects level (0), scale_x (1) or scale_y (2);
// cfg_ready_o is always high. Write only while the unit is empty.
// Throughput: one cell per cycle while the receiver is ready; a saddle
// cell holds the pipeline while its second segment leaves the single
// output register.
// The 16-stage divider pipeline (one quotient bit per stage) sets the depth.
// Reset empties all stages and loads level 0 and both scales 1.0.
// A stalled receiver freezes the whole pipeline; nothing is lost.
`include "assert_macros.svh"

module marching_squares_cell_segments_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mscs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mscs_pkg::VAL_W-1:0]        cfg_data_i,
  // cell input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [mscs_pkg::VAL_W-1:0] corner_top_left_i,
  input  logic signed [mscs_pkg::VAL_W-1:0] corner_top_right_i,
  input  logic signed [mscs_pkg::VAL_W-1:0] corner_bottom_left_i,
  input  logic signed [mscs_pkg::VAL_W-1:0] corner_bottom_right_i,
  input  logic [3:0]                        corner_known_i,
  input  logic [mscs_pkg::POS_W-1:0]        cell_col_i,
  input  logic [mscs_pkg::POS_W-1:0]        cell_row_i,
  // segment output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mscs_pkg::OUT_W-1:0]        start_x_o,
  output logic [mscs_pkg::OUT_W-1:0]        start_y_o,
  output logic [mscs_pkg::OUT_W-1:0]        end_x_o,
  output logic [mscs_pkg::OUT_W-1:0]        end_y_o,
  output logic                              last_segment_o
);
  import mscs_pkg::*;

  localparam logic [COORD_W-1:0] ONE_C = COORD_W'(1) << FRAC_BITS;

  // configuration registers
  logic signed [VAL_W-1:0] level_q;
  logic [SCALE_W-1:0]      scale_x_q, scale_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= '0;
      scale_x_q <= SCALE_W'(1) << FRAC_BITS;
      scale_y_q <= SCALE_W'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LEVEL:   level_q   <= cfg_data_i;
        REG_SCALE_X: scale_x_q <= cfg_data_i[SCALE_W-1:0];
        REG_SCALE_Y: scale_y_q <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register can take data and no saddle split
  logic out_valid_q;
  logic second_q;
  logic m_valid_q, m_two_q;
  logic out_free, split_hold, adv;

  assign out_free   = !out_valid_q || out_ready_i;
  assign split_hold = m_valid_q && m_two_q && !second_q;
  assign adv        = out_free && !split_hold;
  assign in_ready_o = adv;

  // stage 0: input register
  logic                    v0_q;
  logic signed [VAL_W-1:0] tl_q, tr_q, bl_q, br_q;
  logic [3:0]              known_q;
  logic [POS_W-1:0]        col0_q, row0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      tl_q    <= corner_top_left_i;
      tr_q    <= corner_top_right_i;
      bl_q    <= corner_bottom_left_i;
      br_q    <= corner_bottom_right_i;
      known_q <= corner_known_i;
      col0_q  <= cell_col_i;
      row0_q  <= cell_row_i;
    end
  end

  // stage 1: case index, cell check, edge differences
  logic                  v1_q;
  logic [3:0]            cas1_q;
  logic [POS_W-1:0]      col1_q, row1_q;
  logic signed [VAL_W:0] num1_q [4];
  logic signed [VAL_W:0] den1_q [4];
  logic [3:0]            cas1_d;
  logic                  ok1_d;
  logic signed [VAL_W:0] num1_d [4];
  logic signed [VAL_W:0] den1_d [4];

  always_comb begin
    logic signed [VAL_W:0] lv, etl, etr, ebl, ebr;
    lv  = {level_q[VAL_W-1], level_q};
    etl = {tl_q[VAL_W-1], tl_q};
    etr = {tr_q[VAL_W-1], tr_q};
    ebl = {bl_q[VAL_W-1], bl_q};
    ebr = {br_q[VAL_W-1], br_q};
    cas1_d = {bl_q > level_q, br_q > level_q, tr_q > level_q, tl_q > level_q};
    ok1_d  = (known_q == 4'hF) && (col0_q != POS_W'(GRID_SIZE - 1))
          && (row0_q != POS_W'(GRID_SIZE - 1)) && (cas1_d != 4'h0)
          && (cas1_d != 4'hF);
    num1_d[EDGE_TOP]    = lv - etl;  den1_d[EDGE_TOP]    = etr - etl;
    num1_d[EDGE_RIGHT]  = lv - etr;  den1_d[EDGE_RIGHT]  = ebr - etr;
    num1_d[EDGE_BOTTOM] = lv - ebl;  den1_d[EDGE_BOTTOM] = ebr - ebl;
    num1_d[EDGE_LEFT]   = lv - etl;  den1_d[EDGE_LEFT]   = ebl - etl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q && ok1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cas1_q <= cas1_d;
      col1_q <= col0_q;
      row1_q <= row0_q;
      num1_q <= num1_d;
      den1_q <= den1_d;
    end
  end

  // stage 2: sign fold and clamp decision per edge
  logic             v2_q;
  side_t            side2_q;
  logic [VAL_W-1:0] num2_q [4];
  logic [VAL_W-1:0] den2_q [4];
  edge_mode_e       mode2_d [4];
  logic [VAL_W-1:0] num2_d [4];
  logic [VAL_W-1:0] den2_d [4];

  always_comb begin
    logic signed [VAL_W:0] nn, dn;
    for (int e = 0; e < 4; e++) begin
      nn = den1_q[e][VAL_W] ? -num1_q[e] : num1_q[e];
      dn = den1_q[e][VAL_W] ? -den1_q[e] : den1_q[e];
      if (dn == '0 || nn <= 0) begin
        mode2_d[e] = MODE_ZERO;
      end else if (nn >= dn) begin
        mode2_d[e] = MODE_ONE;
      end else begin
        mode2_d[e] = MODE_DIV;
      end
      num2_d[e] = nn[VAL_W-1:0];
      den2_d[e] = dn[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side2_q.cas <= cas1_q;
      side2_q.col <= col1_q;
      side2_q.row <= row1_q;
      for (int e = 0; e < 4; e++) begin
        side2_q.mode[e] <= mode2_d[e];
        // zero the numerator and set the denominator to one for clamped edges so the divider stays in range
        num2_q[e] <= (mode2_d[e] == MODE_DIV) ? num2_d[e] : '0;
        den2_q[e] <= (mode2_d[e] == MODE_DIV) ? den2_d[e] : VAL_W'(1);
      end
    end
  end

  // divider pipelines, one per edge, with cell data alongside
  logic [FRAC_BITS-1:0] quot [4];

  for (genvar e = 0; e < 4; e++) begin : g_div
    mscs_div u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  (num2_q[e]),
      .den_i  (den2_q[e]),
      .quot_o (quot[e])
    );
  end

  logic [DIV_STAGES-1:0] dv_q;
  side_t                 side_q [DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else if (adv) begin
      dv_q <= {dv_q[DIV_STAGES-2:0], v2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= side2_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // point stage: edge crossing coordinates
  logic               vp_q;
  logic [3:0]         casp_q;
  logic [COORD_W-1:0] ptx_q [4];
  logic [COORD_W-1:0] pty_q [4];
  logic [COORD_W-1:0] ptx_d [4];
  logic [COORD_W-1:0] pty_d [4];

  always_comb begin
    logic [COORD_W-1:0] fr [4];
    logic [COORD_W-1:0] x0, y0;
    side_t              sd;
    sd = side_q[DIV_STAGES-1];
    for (int e = 0; e < 4; e++) begin
      case (sd.mode[e])
        MODE_ONE: fr[e] = ONE_C;
        MODE_DIV: fr[e] = COORD_W'(quot[e]);
        default:  fr[e] = '0;
      endcase
    end
    x0 = COORD_W'(sd.col) << FRAC_BITS;
    y0 = COORD_W'(sd.row) << FRAC_BITS;
    ptx_d[EDGE_TOP]    = x0 + fr[EDGE_TOP];     pty_d[EDGE_TOP]    = y0;
    ptx_d[EDGE_RIGHT]  = x0 + ONE_C;            pty_d[EDGE_RIGHT]  = y0 + fr[EDGE_RIGHT];
    ptx_d[EDGE_BOTTOM] = x0 + fr[EDGE_BOTTOM];  pty_d[EDGE_BOTTOM] = y0 + ONE_C;
    ptx_d[EDGE_LEFT]   = x0;                    pty_d[EDGE_LEFT]   = y0 + fr[EDGE_LEFT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (adv) begin
      vp_q <= dv_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      casp_q <= side_q[DIV_STAGES-1].cas;
      ptx_q  <= ptx_d;
      pty_q  <= pty_d;
    end
  end

  // select stage: end points of first and second segment
  logic               vs_q, two_s_q;
  logic [COORD_W-1:0] sel_q [8];
  logic [1:0]         ea0, eb0, ea1, eb1;
  logic               two_d;

  always_comb begin
    ea0 = 2'(EDGE_LEFT);
    eb0 = 2'(EDGE_TOP);
    ea1 = 2'(EDGE_RIGHT);
    eb1 = 2'(EDGE_BOTTOM);
    two_d = 1'b0;
    case (casp_q)
      4'd1, 4'd14: begin ea0 = 2'(EDGE_LEFT);  eb0 = 2'(EDGE_TOP);    end
      4'd2, 4'd13: begin ea0 = 2'(EDGE_TOP);   eb0 = 2'(EDGE_RIGHT);  end
      4'd3, 4'd12: begin ea0 = 2'(EDGE_LEFT);  eb0 = 2'(EDGE_RIGHT);  end
      4'd4, 4'd11: begin ea0 = 2'(EDGE_RIGHT); eb0 = 2'(EDGE_BOTTOM); end
      4'd6, 4'd9:  begin ea0 = 2'(EDGE_TOP);   eb0 = 2'(EDGE_BOTTOM); end
      4'd7, 4'd8:  begin ea0 = 2'(EDGE_LEFT);  eb0 = 2'(EDGE_BOTTOM); end
      4'd5: begin
        ea0 = 2'(EDGE_LEFT);  eb0 = 2'(EDGE_TOP);
        ea1 = 2'(EDGE_RIGHT); eb1 = 2'(EDGE_BOTTOM);
        two_d = 1'b1;
      end
      4'd10: begin
        ea0 = 2'(EDGE_TOP);  eb0 = 2'(EDGE_RIGHT);
        ea1 = 2'(EDGE_LEFT); eb1 = 2'(EDGE_BOTTOM);
        two_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
    end else if (adv) begin
      vs_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      two_s_q  <= two_d;
      sel_q[0] <= ptx_q[ea0];
      sel_q[1] <= pty_q[ea0];
      sel_q[2] <= ptx_q[eb0];
      sel_q[3] <= pty_q[eb0];
      sel_q[4] <= ptx_q[ea1];
      sel_q[5] <= pty_q[ea1];
      sel_q[6] <= ptx_q[eb1];
      sel_q[7] <= pty_q[eb1];
    end
  end

  // multiply stage: scale every coordinate
  logic [PROD_W-1:0] prod_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= vs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_two_q <= two_s_q;
      for (int i = 0; i < 8; i++) begin
        prod_q[i] <= PROD_W'(sel_q[i]) * PROD_W'((i % 2 == 0) ? scale_x_q : scale_y_q);
      end
    end
  end

  // output register, saddle cells leave in two transfers
  logic [OUT_W-1:0] o_q [4];
  logic             last_q;

  function automatic logic [OUT_W-1:0] sat_out(input logic [PROD_W-1:0] p);
    logic [PROD_W-FRAC_BITS-1:0] r;
    r = p[PROD_W-1:FRAC_BITS];
    if (r > (PROD_W-FRAC_BITS)'({OUT_W{1'b1}})) begin
      return {OUT_W{1'b1}};
    end
    return r[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= m_valid_q;
      if (m_valid_q && m_two_q) begin
        second_q <= !second_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && m_valid_q) begin
      for (int i = 0; i < 4; i++) begin
        o_q[i] <= sat_out(second_q ? prod_q[i+4] : prod_q[i]);
      end
      last_q <= !m_two_q || second_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign start_x_o      = o_q[0];
  assign start_y_o      = o_q[1];
  assign end_x_o        = o_q[2];
  assign end_y_o        = o_q[3];
  assign last_segment_o = last_q;

  // checks
  logic first_xfer;

  assign first_xfer = out_valid_o && out_ready_i && !last_segment_o;

  `ASSERT_NEVER(a_second_orphan, second_q && !(m_valid_q && m_two_q), "stray second half")
  `ASSERT_CLK(a_saddle_follow, first_xfer |=> out_valid_o && last_segment_o, "saddle tail missing")
  `ASSERT_CLK(a_hold_on_split, m_valid_q && !adv |=> m_valid_q, "held stage lost data")

endmodule
